### sv/stereo_peak_limiter_top_assert.svh
// Assertion macros for the stereo peak limiter top level.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef STEREO_PEAK_LIMITER_TOP_ASSERT_SVH
`define STEREO_PEAK_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPL_ASSERT_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

### sv/spl_pkg.sv
// Shared types and constants for the stereo peak limiter.
// Used by spl_lane, spl_div and stereo_peak_limiter_top; no dependencies.
package spl_pkg;

  localparam int SAMP_W  = 24;
  localparam int GAIN_W  = 25;
  localparam int COEF_W  = 24;
  localparam int CEIL_W  = 23;
  localparam int QUO_W   = 24;
  localparam int CFG_W   = 24;
  localparam int CH_MAX  = 2;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'd16777216;

  localparam logic [CEIL_W-1:0] CEIL_RST    = 23'd1013012;
  localparam logic [COEF_W-1:0] ATTACK_RST  = 24'd16345947;
  localparam logic [COEF_W-1:0] RELEASE_RST = 24'd16759751;

  localparam logic signed [SAMP_W-1:0] SAMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMP_W-1:0] SAMP_MIN = 24'sh800000;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CEILING = 2'd0;
  localparam cfg_idx_t CFG_ATTACK  = 2'd1;
  localparam cfg_idx_t CFG_RELEASE = 2'd2;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample_left;
    logic signed [SAMP_W-1:0] sample_right;
  } in_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] out_left;
    logic signed [SAMP_W-1:0] out_right;
    logic [GAIN_W-1:0]        gain_now;
  } out_t;

  typedef struct packed {
    logic load;
    logic mul;
  } lane_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/spl_lane.sv
// One channel lane: holds the sample, reports its magnitude, applies the gain.
// Depends on spl_pkg.
module spl_lane
  import spl_pkg::*;
(
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic signed [SAMP_W-1:0] sample,
  input  logic [GAIN_W-1:0]        gain,
  output logic [SAMP_W-1:0]        mag,
  output logic signed [SAMP_W-1:0] res
);

  localparam int PROD_W = SAMP_W + GAIN_W + 1;

  logic signed [SAMP_W-1:0] sample_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-25:0] quo;

  assign prod_nxt = PROD_W'(sample_r * $signed({1'b0, gain}));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_r <= sample;
    end
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
  end

  // Most negative sample maps to 2^23, which still fits unsigned.
  assign mag = sample_r[SAMP_W-1] ? SAMP_W'(~sample_r + 1'b1) : SAMP_W'(sample_r);

  // Arithmetic shift floors toward minus infinity, then clamp.
  assign quo = prod_r[PROD_W-1:24];

  always_comb begin
    if (quo[PROD_W-25] != quo[SAMP_W-1] || quo[PROD_W-26] != quo[SAMP_W-1]) begin
      res = quo[PROD_W-25] ? SAMP_MIN : SAMP_MAX;
    end else begin
      res = quo[SAMP_W-1:0];
    end
  end

endmodule

### sv/spl_div.sv
// Restoring divider: (ceiling * 2^24) / peak, one quotient bit per cycle.
// Requires ceiling < peak so the quotient fits 24 bits. Depends on spl_pkg.
module spl_div
  import spl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [CEIL_W-1:0] dividend,
  input  logic [SAMP_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [QUO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [SAMP_W-1:0] rem_r;
  logic [SAMP_W-1:0] dvs_r;
  logic [QUO_W-1:0]  quo_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [SAMP_W:0]   shifted;
  logic              fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= SAMP_W'(dividend);
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      // Remainder stays below the divisor, so the top bit drops cleanly.
      rem_r <= fits ? SAMP_W'(shifted - {1'b0, dvs_r}) : shifted[SAMP_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

### sv/stereo_peak_limiter_top.sv
// Stereo peak limiter: per-channel lanes, a shared divider and the envelope path.
// Depends on spl_pkg, spl_lane, spl_div and stereo_peak_limiter_top_assert.svh.
//
// A frame that stays at or below the ceiling passes through the peak, envelope
// multiply, envelope add, scale and saturate states into the output register; a
// frame above the ceiling also waits in the 24-step serial divider that forms
// ceiling / peak. One frame is in work at a time; the next is accepted as soon as
// the previous result has moved to the output register, even if that result is
// still stalled there.
// The configuration port is always ready and is meant to be written only while
// no frame is in work. The envelope resets to unity gain.
module stereo_peak_limiter_top
  import spl_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  `include "stereo_peak_limiter_top_assert.svh"

  localparam int EPROD_W = COEF_W + GAIN_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PEAK = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_EMUL = 7'b0001000,
    ST_EADD = 7'b0010000,
    ST_SMUL = 7'b0100000,
    ST_SAT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CEIL_W-1:0]  ceiling_r;
  logic [COEF_W-1:0]  attack_r;
  logic [COEF_W-1:0]  release_r;
  logic [GAIN_W-1:0]  env_r;
  logic [GAIN_W-1:0]  needed_r;
  logic [EPROD_W-1:0] eprod_r;
  logic               down_r;
  logic               out_valid_r;
  out_t               out_r;

  logic                     in_acc;
  logic                     out_free;
  lane_ctl_t                lane_ctl;
  logic signed [SAMP_W-1:0] samp   [CH_MAX];
  logic [SAMP_W-1:0]        mags   [CH_MAX];
  logic signed [SAMP_W-1:0] res    [CH_MAX];
  logic [SAMP_W-1:0]        peak;
  logic                     over;
  div_stat_t                div_st;
  logic [QUO_W-1:0]         quo;
  logic                     env_ge;
  logic [COEF_W-1:0]        coeff;
  logic [GAIN_W-1:0]        diff;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign samp[0] = in_data.sample_left;
  assign samp[1] = in_data.sample_right;

  assign lane_ctl.load = in_acc;
  assign lane_ctl.mul  = (state_r == ST_SMUL);

  for (genvar i = 0; i < CH_MAX; i++) begin : g_lane
    if (i < CHANNELS) begin : g_used
      spl_lane u_lane (
        .clk    (clk),
        .ctl    (lane_ctl),
        .sample (samp[i]),
        .gain   (env_r),
        .mag    (mags[i]),
        .res    (res[i])
      );
    end else begin : g_unused
      assign mags[i] = '0;
      assign res[i]  = '0;
    end
  end

  // Merge: largest magnitude over the lanes.
  always_comb begin
    peak = '0;
    for (int i = 0; i < CH_MAX; i++) begin
      if (mags[i] > peak) begin
        peak = mags[i];
      end
    end
  end

  assign over = peak > SAMP_W'(ceiling_r);

  spl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    ((state_r == ST_PEAK) && over),
    .dividend (ceiling_r),
    .divisor  (peak),
    .stat     (div_st),
    .quotient (quo)
  );

  // Envelope step: pick the pole, then move toward the needed gain.
  assign env_ge = env_r >= needed_r;
  assign coeff  = env_ge ? attack_r : release_r;
  assign diff   = env_ge ? (env_r - needed_r) : (needed_r - env_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_PEAK;
      ST_PEAK: state_nxt = over ? ST_DIV : ST_EMUL;
      ST_DIV:  if (div_st.done) state_nxt = ST_EMUL;
      ST_EMUL: state_nxt = ST_EADD;
      ST_EADD: state_nxt = ST_SMUL;
      ST_SMUL: state_nxt = ST_SAT;
      ST_SAT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      env_r       <= UNITY_GAIN;
      ceiling_r   <= CEIL_RST;
      attack_r    <= ATTACK_RST;
      release_r   <= RELEASE_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_CEILING: ceiling_r <= cfg_data[CEIL_W-1:0];
          CFG_ATTACK:  attack_r  <= cfg_data[COEF_W-1:0];
          CFG_RELEASE: release_r <= cfg_data[COEF_W-1:0];
          default: ;
        endcase
      end
      if (state_r == ST_EADD) begin
        env_r <= down_r ? (needed_r + eprod_r[EPROD_W-1:24])
                        : (needed_r - eprod_r[EPROD_W-1:24]);
      end
      if (state_r == ST_SAT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PEAK && !over) begin
      needed_r <= UNITY_GAIN;
    end else if (state_r == ST_DIV && div_st.done) begin
      needed_r <= GAIN_W'(quo);
    end
    if (state_r == ST_EMUL) begin
      eprod_r <= coeff * diff;
      down_r  <= env_ge;
    end
    if (state_r == ST_SAT && out_free) begin
      out_r.out_left  <= res[0];
      out_r.out_right <= res[1];
      out_r.gain_now  <= env_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SPL_ASSERT_NEXT(a_accept_peak, in_acc, state_r == ST_PEAK, "accepted beat did not start work")
  `SPL_ASSERT_SAME(a_div_state, div_st.done || div_st.busy, state_r == ST_DIV,
                   "divider active outside divide state")
  `SPL_ASSERT_SAME(a_env_bound, out_valid_r, out_r.gain_now <= UNITY_GAIN,
                   "envelope gain above unity")
  `SPL_ASSERT_NEXT(a_sat_hold, state_r == ST_SAT && !out_free, state_r == ST_SAT,
                   "result left while output register busy")

endmodule

### tb/tb_stereo_peak_limiter_top.sv
// Self-checking testbench for stereo_peak_limiter_top: directed and random stereo frames,
// register writes between phases, random idling on both channels and one long output hold.
// Depends on spl_pkg and the stereo_peak_limiter_top RTL; uses no files.
`timescale 1ns / 100ps

module tb_stereo_peak_limiter_top;
  import spl_pkg::*;

  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam longint UNITY = 64'd16777216;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT = 20000;

  typedef enum {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_CEILING;
  logic [CFG_W-1:0] cfg_data = '0;

  // limiter state as the block should hold it
  logic [CEIL_W-1:0] lim_ceiling = CEIL_RST;
  logic [COEF_W-1:0] lim_attack = ATTACK_RST;
  logic [COEF_W-1:0] lim_release = RELEASE_RST;
  logic [GAIN_W-1:0] lim_envelope = UNITY_GAIN;

  out_t pending_frames[$];
  int err_count = 0;
  int frames_sent = 0;
  int loud_frames = 0;
  int reg_writes = 0;
  int results_checked = 0;

  // sender burst shaping; gap_max of zero keeps valid up
  int gap_max = 0;
  int burst_left = 0;

  rx_mode_t rx_mode = RX_FREE;
  int hold_cnt = 0;
  logic [15:0] rx_pattern = 16'b0011_1000_0110_0001;

  stereo_peak_limiter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [SAMP_W-1:0] clamp_sample(longint v);
    longint c;
    c = v;
    if (c > 64'sd8388607) c = 64'sd8388607;
    if (c < -64'sd8388608) c = -64'sd8388608;
    return c[SAMP_W-1:0];
  endfunction

  // Q4.20 sample times Q1.24 gain, floor shift back to Q4.20, saturate
  function automatic logic signed [SAMP_W-1:0] scale_sat(longint s, longint g);
    return clamp_sample((s * g) >>> 24);
  endfunction

  // Magnitude in [0, hi] with a random sign
  function automatic longint rand_signed(longint hi);
    longint m;
    m = longint'($urandom_range(0, 32'(hi)));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Advance the envelope by one frame and return the result that frame should give.
  function automatic out_t limit_frame(in_t f);
    longint l, r, ml, mr, peak, need, env, coef;
    out_t o;
    l = longint'($signed(f.sample_left));
    r = longint'($signed(f.sample_right));
    ml = (l < 0) ? -l : l;
    mr = (r < 0) ? -r : r;
    peak = (mr > ml) ? mr : ml;
    need = UNITY;
    if (peak > longint'(lim_ceiling)) begin
      need = (longint'(lim_ceiling) << 24) / peak;
      loud_frames++;
    end
    env = longint'(lim_envelope);
    coef = (need < env) ? longint'(lim_attack) : longint'(lim_release);
    if (env >= need) env = need + ((coef * (env - need)) >> 24);
    else env = need - ((coef * (need - env)) >> 24);
    lim_envelope = env[GAIN_W-1:0];
    o.out_left = scale_sat(l, env);
    o.out_right = scale_sat(r, env);
    o.gain_now = env[GAIN_W-1:0];
    return o;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        flag_error($sformatf("unexpected result beat %h", out_data));
      end else begin
        want = pending_frames.pop_front();
        results_checked++;
        if (out_data.out_left !== want.out_left)
          flag_error($sformatf("out_left got %0d want %0d (result %0d)",
                               out_data.out_left, want.out_left, results_checked));
        if (out_data.out_right !== want.out_right)
          flag_error($sformatf("out_right got %0d want %0d (result %0d)",
                               out_data.out_right, want.out_right, results_checked));
        if (out_data.gain_now !== want.gain_now)
          flag_error($sformatf("gain_now got %0d want %0d (result %0d)",
                               out_data.gain_now, want.gain_now, results_checked));
      end
    end
  end

  // Output stall: a counted hold takes priority over the current pattern.
  always @(posedge clk) begin
    if (hold_cnt > 0) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt - 1;
    end else begin
      case (rx_mode)
        RX_FREE: out_stall <= 1'b0;
        RX_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        RX_PATTERN: begin
          out_stall <= rx_pattern[0];
          rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // Offer one frame, hold it until accepted, then maybe open a gap.
  task automatic send_frame(in_t f);
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (in_stall);
    pending_frames.push_back(limit_frame(f));
    frames_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_pair(longint l, longint r);
    in_t f;
    f.sample_left = clamp_sample(l);
    f.sample_right = clamp_sample(r);
    send_frame(f);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CEILING: lim_ceiling = val[CEIL_W-1:0];
      CFG_ATTACK:  lim_attack = val;
      CFG_RELEASE: lim_release = val;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_frames.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_frames.size()));
      pending_frames.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_coef();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return CFG_W'($urandom_range(0, 24'hFFFFFF));
      default: return CFG_W'($urandom_range(24'hE00000, 24'hFFFFFF));
    endcase
  endfunction

  function automatic in_t rand_frame();
    in_t f;
    logic [31:0] rnd;
    longint lim;
    longint near;
    lim = longint'(lim_ceiling);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        rnd = $urandom;
        f.sample_left = rnd[SAMP_W-1:0];
        rnd = $urandom;
        f.sample_right = rnd[SAMP_W-1:0];
      end
      4, 5, 6: begin
        f.sample_left = clamp_sample(rand_signed(lim));
        f.sample_right = clamp_sample(rand_signed(lim));
      end
      7, 8: begin
        near = lim + longint'($urandom_range(0, 4)) - 2;
        f.sample_left = clamp_sample($urandom_range(0, 1) ? -near : near);
        f.sample_right = clamp_sample(rand_signed(lim));
        if ($urandom_range(0, 1)) f = {f.sample_right, f.sample_left};
      end
      default: begin
        case ($urandom_range(0, 3))
          0: f.sample_left = SAMP_MAX;
          1: f.sample_left = SAMP_MIN;
          2: f.sample_left = '0;
          default: f.sample_left = '1;
        endcase
        rnd = $urandom;
        f.sample_right = rnd[SAMP_W-1:0];
      end
    endcase
    return f;
  endfunction

  task automatic test_defaults();
    longint c;
    c = longint'(CEIL_RST);
    send_pair(0, 0);
    send_pair(c, -c);
    send_pair(c + 1, 0);
    send_pair(0, -(c + 1));
    send_pair(8388607, -8388608);
    send_pair(-8388608, 8388607);
    send_pair(12345, -200);
    send_pair(-1, 1);
    send_pair(1000, -1000);
    send_pair(-3000000, 2500000);
  endtask

  task automatic test_ceiling_zero();
    drain();
    write_reg(CFG_CEILING, '0);
    write_reg(CFG_ATTACK, '0);
    send_pair(0, 0);
    send_pair(1, 0);
    send_pair(0, -1);
    send_pair(0, 0);
    send_pair(8388607, -8388608);
  endtask

  task automatic test_coeff_extremes();
    drain();
    write_reg(CFG_CEILING, 24'h7FFFFF);
    write_reg(CFG_ATTACK, 24'hFFFFFF);
    write_reg(CFG_RELEASE, 24'hFFFFFF);
    send_pair(8388607, 8388607);
    send_pair(-8388608, 0);
    send_pair(0, -8388608);
    drain();
    write_reg(CFG_RELEASE, '0);
    write_reg(CFG_ATTACK, '0);
    send_pair(-8388608, -8388608);
    send_pair(5, 5);
  endtask

  // Bit 23 of a ceiling write and writes to the spare index must leave no trace.
  task automatic test_register_bits();
    drain();
    write_reg(CFG_CEILING, 24'hFFFFFF);
    write_reg(CFG_UNUSED, 24'h000001);
    send_pair(-8388608, 0);
    send_pair(100000, 0);
    drain();
    write_reg(CFG_CEILING, 24'h800000 | 24'(CEIL_RST));
    write_reg(CFG_ATTACK, ATTACK_RST);
    write_reg(CFG_RELEASE, RELEASE_RST);
    send_pair(4000000, -4000000);
  endtask

  // Hold the output long enough that the block fills and stalls its input.
  task automatic test_backpressure();
    drain();
    gap_max = 0;
    rx_mode = RX_FREE;
    hold_cnt <= 300;
    repeat (24) send_frame(rand_frame());
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      drain();
      case ($urandom_range(0, 5))
        0: write_reg(CFG_CEILING, '0);
        1: write_reg(CFG_CEILING, 24'h7FFFFF);
        2: write_reg(CFG_CEILING, CFG_W'($urandom_range(0, 24'hFFFFFF)));
        default: write_reg(CFG_CEILING, CFG_W'($urandom_range(200000, 2000000)));
      endcase
      write_reg(CFG_ATTACK, pick_coef());
      write_reg(CFG_RELEASE, pick_coef());
      // first phase runs with no idling on either side
      gap_max = (p == 0) ? 0 : $urandom_range(2, 40);
      if (p == 0) rx_mode = RX_FREE;
      else if (p % 2 == 1) rx_mode = RX_RANDOM;
      else rx_mode = RX_PATTERN;
      repeat (120) send_frame(rand_frame());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_ceiling_zero();
    test_coeff_extremes();
    test_register_bits();
    test_backpressure();
    test_random_phases();
    drain();
    $display("Checked %0d of %0d frames (%0d above the ceiling) across %0d register writes,",
             results_checked, frames_sent, loud_frames, reg_writes);
    $display("including zero and full-scale ceilings, coefficient extremes and a long hold.");
    if (err_count == 0) begin
      $display("stereo_peak_limiter_top verification clean");
    end else begin
      $display("stereo_peak_limiter_top verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("stereo_peak_limiter_top verification failed");
    $finish;
  end

endmodule
